[hdl/mrif_pkg.sv]
// Package for the mixed-radix index converter with fftshift.
// Holds widths, operation and register codes, sequencer states and the divider
// request/response types. No dependencies.
package mrif_pkg;

  // Widths fixed by the field definitions.
  localparam int unsigned FIELD_DIMS = 4;
  localparam int unsigned DIM_W      = 2;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned LIN_W      = 32;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DIV_CNT_W  = 5;

  // Default for the top-level dimension limit.
  localparam int unsigned MAX_DIMS_DEF = 4;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_SPLIT = 2'd0,
    OP_JOIN  = 2'd1,
    OP_SHIFT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_3    = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MAC,
    ST_FINISH
  } state_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [LIN_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [LIN_W-1:0]  quotient;
    logic [SIZE_W-1:0] remainder;
  } div_rsp_t;

endpackage

[hdl/mixed_radix_index_fftshift.sv]
// Mixed-radix index converter with fftshift (top level).
// Usage:
//   Configuration: cfg_index 0 sets the dimension count, 1 to 4 set the
//   extents of dimensions 0 to 3. Write only while the block is idle;
//   cfg_ready is always high. Writes to other indexes are ignored.
//   Input: a transaction is taken when in_valid is high and in_stall low.
//   in_stall stays high while an item is in work.
//   Output: one result transaction per input, held in an output register
//   until out_valid is high and out_stall low.
//   Sequence per item: a split (0) makes one pass of the shared radix-2
//   divider per active dimension, last dimension first, with a start state
//   and a wait state per pass. An fftshift (2) makes the same passes and
//   then, when in range, one multiply-add per dimension; a join (1) makes
//   only the multiply-adds. An unknown op or an early range error goes
//   straight to the finish state. The block returns to idle after each
//   item and takes the next transaction only there.
//   A new item is taken while a finished result still waits; it is written
//   to the output register only once that result has been taken.
//   Reset (synchronous, active low) sets one dimension of extent 1 and
//   empties the output register.
module mixed_radix_index_fftshift #(
  parameter int unsigned MAX_DIMS = mrif_pkg::MAX_DIMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrif_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mrif_pkg::SIZE_W-1:0]         cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic [mrif_pkg::LIN_W-1:0]          in_linear_index,
  input  logic [mrif_pkg::SIZE_W-1:0]         in_coord_0,
  input  logic [mrif_pkg::SIZE_W-1:0]         in_coord_1,
  input  logic [mrif_pkg::SIZE_W-1:0]         in_coord_2,
  input  logic [mrif_pkg::SIZE_W-1:0]         in_coord_3,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mrif_pkg::LIN_W-1:0]          out_result_index,
  output logic [mrif_pkg::SIZE_W-1:0]         out_coord_0,
  output logic [mrif_pkg::SIZE_W-1:0]         out_coord_1,
  output logic [mrif_pkg::SIZE_W-1:0]         out_coord_2,
  output logic [mrif_pkg::SIZE_W-1:0]         out_coord_3,
  output logic                                out_range_error
);

  localparam int unsigned ACT_MAX =
    (MAX_DIMS < mrif_pkg::FIELD_DIMS) ? MAX_DIMS : mrif_pkg::FIELD_DIMS;
  localparam logic [mrif_pkg::CNT_W-1:0] ACT_MAX_C = mrif_pkg::CNT_W'(ACT_MAX);
  localparam int unsigned PROD_W = mrif_pkg::LIN_W + mrif_pkg::SIZE_W;

  // Configuration registers
  logic [mrif_pkg::CNT_W-1:0]   dim_count_r;
  logic [mrif_pkg::SIZE_W-1:0]  size_r [mrif_pkg::FIELD_DIMS];

  // Sequencer and working registers
  mrif_pkg::state_t             state_r, state_nxt;
  mrif_pkg::op_t                op_r;
  logic [mrif_pkg::DIM_W-1:0]   dim_r;
  logic [mrif_pkg::DIM_W-1:0]   last_r;
  logic [mrif_pkg::LIN_W-1:0]   lin_r;
  logic [mrif_pkg::SIZE_W-1:0]  coord_r [mrif_pkg::FIELD_DIMS];
  logic [mrif_pkg::LIN_W-1:0]   acc_r;
  logic                         ovf_r;
  logic                         err_r;

  // Output register
  logic                         out_valid_r;
  logic [mrif_pkg::LIN_W-1:0]   out_index_r;
  logic [mrif_pkg::SIZE_W-1:0]  out_coord_r [mrif_pkg::FIELD_DIMS];
  logic                         out_err_r;

  // Accept-time decode
  mrif_pkg::op_t                in_op;
  logic [mrif_pkg::SIZE_W-1:0]  in_coord [mrif_pkg::FIELD_DIMS];
  logic [mrif_pkg::CNT_W-1:0]   n_act;
  logic [mrif_pkg::DIM_W-1:0]   n_last;
  logic [mrif_pkg::FIELD_DIMS-1:0] active;
  logic                         zero_size;
  logic                         coord_bad;
  logic                         in_err;
  logic                         accept;

  // Multiply-add and shift datapath
  logic [mrif_pkg::SIZE_W-1:0]  cur_size;
  logic [mrif_pkg::SIZE_W:0]    shift_sum;
  logic [mrif_pkg::SIZE_W-1:0]  shift_coord;
  logic [mrif_pkg::SIZE_W-1:0]  mac_coord;
  logic [PROD_W-1:0]            mac_prod;
  logic [PROD_W:0]              mac_sum;

  // Handshake helpers
  logic                         out_free;
  logic                         quo_nonzero;

  mrif_pkg::div_req_t           div_req;
  mrif_pkg::div_rsp_t           div_rsp;

  assign in_op       = mrif_pkg::op_t'(in_operation);
  assign in_coord[0] = in_coord_0;
  assign in_coord[1] = in_coord_1;
  assign in_coord[2] = in_coord_2;
  assign in_coord[3] = in_coord_3;

  // Active dimension count, clamped to one through the supported maximum.
  always_comb begin
    if (dim_count_r == '0) begin
      n_act = mrif_pkg::CNT_W'(1);
    end else if (dim_count_r > ACT_MAX_C) begin
      n_act = ACT_MAX_C;
    end else begin
      n_act = dim_count_r;
    end
    n_last = mrif_pkg::DIM_W'(n_act - mrif_pkg::CNT_W'(1));
  end

  // Range checks that can be decided when the transaction is taken.
  always_comb begin
    zero_size = 1'b0;
    coord_bad = 1'b0;
    for (int i = 0; i < mrif_pkg::FIELD_DIMS; i++) begin
      active[i] = (mrif_pkg::CNT_W'(i) < n_act);
      if (active[i] && (size_r[i] == '0)) zero_size = 1'b1;
      if (active[i] && (in_coord[i] >= size_r[i])) coord_bad = 1'b1;
    end
    in_err = (in_op != mrif_pkg::OP_NONE) &&
             (zero_size || ((in_op == mrif_pkg::OP_JOIN) && coord_bad));
  end

  assign accept      = (state_r == mrif_pkg::ST_IDLE) && in_valid;
  assign out_free    = !out_valid_r || !out_stall;
  assign quo_nonzero = (div_rsp.quotient != '0);

  // Horner step: acc * size + coordinate, with fftshift rotation for op 2.
  always_comb begin
    cur_size    = size_r[dim_r];
    shift_sum   = {1'b0, coord_r[dim_r]} + {2'b0, cur_size[mrif_pkg::SIZE_W-1:1]};
    if (shift_sum >= {1'b0, cur_size}) begin
      shift_coord = mrif_pkg::SIZE_W'(shift_sum - {1'b0, cur_size});
    end else begin
      shift_coord = shift_sum[mrif_pkg::SIZE_W-1:0];
    end
    mac_coord = (op_r == mrif_pkg::OP_SHIFT) ? shift_coord : coord_r[dim_r];
    mac_prod  = PROD_W'(acc_r) * PROD_W'(cur_size);
    mac_sum   = {1'b0, mac_prod} + (PROD_W + 1)'(mac_coord);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrif_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_err || (in_op == mrif_pkg::OP_NONE)) begin
            state_nxt = mrif_pkg::ST_FINISH;
          end else if (in_op == mrif_pkg::OP_JOIN) begin
            state_nxt = mrif_pkg::ST_MAC;
          end else begin
            state_nxt = mrif_pkg::ST_DIV_START;
          end
        end
      end
      mrif_pkg::ST_DIV_START: begin
        state_nxt = mrif_pkg::ST_DIV_WAIT;
      end
      mrif_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (dim_r != '0) begin
            state_nxt = mrif_pkg::ST_DIV_START;
          end else if (quo_nonzero || (op_r == mrif_pkg::OP_SPLIT)) begin
            state_nxt = mrif_pkg::ST_FINISH;
          end else begin
            state_nxt = mrif_pkg::ST_MAC;
          end
        end
      end
      mrif_pkg::ST_MAC: begin
        if (dim_r == last_r) state_nxt = mrif_pkg::ST_FINISH;
      end
      mrif_pkg::ST_FINISH: begin
        if (out_free) state_nxt = mrif_pkg::ST_IDLE;
      end
      default: state_nxt = mrif_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = lin_r;
    div_req.divisor  = cur_size;
    case (state_r)
      mrif_pkg::ST_IDLE:      in_stall = 1'b0;
      mrif_pkg::ST_DIV_START: div_req.start = 1'b1;
      mrif_pkg::ST_DIV_WAIT,
      mrif_pkg::ST_MAC,
      mrif_pkg::ST_FINISH:    in_stall = 1'b1;
      default:                in_stall = 1'b1;
    endcase
  end

  // Shared divider for the division passes of split and fftshift.
  mrif_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Control registers: state, configuration, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrif_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      dim_count_r <= mrif_pkg::CNT_W'(1);
      for (int i = 0; i < mrif_pkg::FIELD_DIMS; i++) begin
        size_r[i] <= mrif_pkg::SIZE_W'(1);
      end
    end else begin
      state_r <= state_nxt;
      if ((state_r == mrif_pkg::ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          mrif_pkg::CFG_DIM_COUNT: dim_count_r <= cfg_data[mrif_pkg::CNT_W-1:0];
          mrif_pkg::CFG_SIZE_0:    size_r[0] <= cfg_data;
          mrif_pkg::CFG_SIZE_1:    size_r[1] <= cfg_data;
          mrif_pkg::CFG_SIZE_2:    size_r[2] <= cfg_data;
          mrif_pkg::CFG_SIZE_3:    size_r[3] <= cfg_data;
          default:                 dim_count_r <= dim_count_r;
        endcase
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    case (state_r)
      mrif_pkg::ST_IDLE: begin
        if (accept) begin
          op_r   <= in_op;
          lin_r  <= in_linear_index;
          last_r <= n_last;
          dim_r  <= (in_op == mrif_pkg::OP_JOIN) ? '0 : n_last;
          acc_r  <= '0;
          ovf_r  <= 1'b0;
          err_r  <= in_err;
          for (int i = 0; i < mrif_pkg::FIELD_DIMS; i++) begin
            coord_r[i] <= ((in_op == mrif_pkg::OP_JOIN) && active[i]) ? in_coord[i] : '0;
          end
        end
      end
      mrif_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          coord_r[dim_r] <= div_rsp.remainder;
          lin_r          <= div_rsp.quotient;
          if (dim_r == '0) begin
            err_r <= err_r || quo_nonzero;
          end else begin
            dim_r <= dim_r - mrif_pkg::DIM_W'(1);
          end
        end
      end
      mrif_pkg::ST_MAC: begin
        acc_r <= mac_sum[mrif_pkg::LIN_W-1:0];
        ovf_r <= ovf_r || (mac_sum[PROD_W:mrif_pkg::LIN_W] != '0);
        dim_r <= dim_r + mrif_pkg::DIM_W'(1);
      end
      default: begin
        dim_r <= dim_r;
      end
    endcase
  end

  // Result register, written as the item finishes.
  always_ff @(posedge clk) begin
    if ((state_r == mrif_pkg::ST_FINISH) && out_free) begin
      if (err_r || ovf_r) begin
        out_index_r <= '0;
        out_err_r   <= 1'b1;
        for (int i = 0; i < mrif_pkg::FIELD_DIMS; i++) begin
          out_coord_r[i] <= '0;
        end
      end else begin
        out_err_r <= 1'b0;
        case (op_r)
          mrif_pkg::OP_SPLIT: begin
            out_index_r <= '0;
            for (int i = 0; i < mrif_pkg::FIELD_DIMS; i++) begin
              out_coord_r[i] <= coord_r[i];
            end
          end
          mrif_pkg::OP_JOIN,
          mrif_pkg::OP_SHIFT: begin
            out_index_r <= acc_r;
            for (int i = 0; i < mrif_pkg::FIELD_DIMS; i++) begin
              out_coord_r[i] <= '0;
            end
          end
          default: begin
            out_index_r <= '0;
            for (int i = 0; i < mrif_pkg::FIELD_DIMS; i++) begin
              out_coord_r[i] <= '0;
            end
          end
        endcase
      end
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_coord_0      = out_coord_r[0];
  assign out_coord_1      = out_coord_r[1];
  assign out_coord_2      = out_coord_r[2];
  assign out_coord_3      = out_coord_r[3];
  assign out_range_error  = out_err_r;

endmodule

[hdl/mrif_div.sv]
// Radix-2 restoring divider: 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle. Depends on mrif_pkg for widths and request/response types.
module mrif_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mrif_pkg::div_req_t req,
  output mrif_pkg::div_rsp_t rsp
);

  logic                               busy_r;
  logic                               done_r;
  logic [mrif_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [mrif_pkg::SIZE_W-1:0]        div_r;
  logic [mrif_pkg::SIZE_W-1:0]        rem_r;
  logic [mrif_pkg::LIN_W-1:0]         quo_r;

  logic [mrif_pkg::SIZE_W:0]          trial;
  logic [mrif_pkg::SIZE_W:0]          diff;
  logic                               fits;
  logic [mrif_pkg::SIZE_W-1:0]        rem_nxt;

  // One trial subtraction per cycle; the remainder stays below the divisor.
  always_comb begin
    trial   = {rem_r, quo_r[mrif_pkg::LIN_W-1]};
    diff    = trial - {1'b0, div_r};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? diff[mrif_pkg::SIZE_W-1:0] : trial[mrif_pkg::SIZE_W-1:0];
  end

  // Control: the count runs over all quotient bits, done pulses once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + mrif_pkg::DIV_CNT_W'(1);
        if (cnt_r == {mrif_pkg::DIV_CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
        end
      end
      done_r <= !req.start && busy_r && (cnt_r == {mrif_pkg::DIV_CNT_W{1'b1}});
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[mrif_pkg::LIN_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign rsp = '{done: done_r, quotient: quo_r, remainder: rem_r};

endmodule

[hdl/mrif_check.sv]
// Port-level checker for the mixed-radix index converter, with its bind to
// the top level. Sees only the top-level ports; no package dependency.
module mrif_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_index,
  input logic [15:0] out_coord_0,
  input logic [15:0] out_coord_1,
  input logic [15:0] out_coord_2,
  input logic [15:0] out_coord_3,
  input logic        out_range_error
);

  logic coords_zero;
  assign coords_zero = (out_coord_0 == 16'd0) && (out_coord_1 == 16'd0) &&
                       (out_coord_2 == 16'd0) && (out_coord_3 == 16'd0);

  // The block holds off the next transaction while one is in work.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transaction");

  // A range error clears every other result field.
  a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> ((out_result_index == 32'd0) && coords_zero))
    else $error("range error with nonzero result fields");

  // A result carries either an index or coordinates, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_index == 32'd0) || coords_zero))
    else $error("result carries both an index and coordinates");

  // Reset leaves no result pending and the input open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("state not cleared by reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result withdrawn");

endmodule

bind mixed_radix_index_fftshift mrif_check u_mrif_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_index (out_result_index),
  .out_coord_0      (out_coord_0),
  .out_coord_1      (out_coord_1),
  .out_coord_2      (out_coord_2),
  .out_coord_3      (out_coord_3),
  .out_range_error  (out_range_error)
);

[sim/tb_mixed_radix_index_fftshift.sv]
// Self-checking testbench for mixed_radix_index_fftshift: split, join and fftshift
// transactions are checked against an in-bench predictor under random idling on both sides.
// Depends on hdl/mrif_pkg.sv and hdl/mixed_radix_index_fftshift.sv.
`timescale 1ns / 100ps

module tb_mixed_radix_index_fftshift;

  // One input transaction and one result transaction.
  typedef struct packed {
    mrif_pkg::op_t    op;
    logic [31:0]      lin;
    logic [3:0][15:0] coord;
  } index_request_t;

  typedef struct packed {
    logic [31:0]      index;
    logic [3:0][15:0] coord;
    logic             range_err;
  } index_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_linear_index = '0;
  logic [15:0] in_coord_0 = '0;
  logic [15:0] in_coord_1 = '0;
  logic [15:0] in_coord_2 = '0;
  logic [15:0] in_coord_3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_index;
  logic [15:0] out_coord_0;
  logic [15:0] out_coord_1;
  logic [15:0] out_coord_2;
  logic [15:0] out_coord_3;
  logic        out_range_error;

  // Shadow copy of the configuration registers.
  logic [2:0]  shadow_dims = 3'd1;
  logic [15:0] shadow_size [4] = '{16'd1, 16'd1, 16'd1, 16'd1};

  index_request_t pending_requests [$];
  index_result_t  expected_results [$];
  index_request_t req_on_bus;
  index_result_t  seen_result;
  index_result_t  want_result;
  int unsigned    requests_queued = 0;
  int unsigned    results_checked = 0;
  int unsigned    mismatches = 0;
  int unsigned    send_gap = 0;
  int unsigned    stall_left = 0;
  bit             no_idle = 1'b0;

  mixed_radix_index_fftshift i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_linear_index  (in_linear_index),
    .in_coord_0       (in_coord_0),
    .in_coord_1       (in_coord_1),
    .in_coord_2       (in_coord_2),
    .in_coord_3       (in_coord_3),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_coord_0      (out_coord_0),
    .out_coord_1      (out_coord_1),
    .out_coord_2      (out_coord_2),
    .out_coord_3      (out_coord_3),
    .out_range_error  (out_range_error)
  );

  always #2 clk = ~clk;

  // Dimension count as the block uses it: zero acts as one, the top is clamped to four.
  function automatic int unsigned active_dims();
    if (shadow_dims == 3'd0) return 1;
    if (shadow_dims > 3'd4) return 4;
    return 32'(shadow_dims);
  endfunction

  function automatic logic [63:0] extent_product(int unsigned n);
    logic [63:0] prod;
    prod = 64'd1;
    for (int i = 0; i < n; i++) prod = prod * 64'(shadow_size[i]);
    return prod;
  endfunction

  // Expected result of one transaction under the current register settings.
  function automatic index_result_t convert_index(index_request_t req);
    index_result_t    r;
    logic [3:0][31:0] c;
    logic [63:0]      rem;
    logic [63:0]      acc;
    logic [63:0]      stride;
    int unsigned      n;
    bit               ok;
    bit               join_needed;
    r = '0;
    c = '0;
    ok = 1'b1;
    join_needed = 1'b0;
    n = active_dims();
    case (req.op)
      mrif_pkg::OP_SPLIT, mrif_pkg::OP_SHIFT: begin
        if (64'(req.lin) >= extent_product(n)) begin
          ok = 1'b0;
        end else begin
          // Peel off the fastest dimension first.
          rem = 64'(req.lin);
          for (int i = n - 1; i >= 0; i--) begin
            c[i] = 32'(rem % 64'(shadow_size[i]));
            rem = rem / 64'(shadow_size[i]);
          end
          if (req.op == mrif_pkg::OP_SPLIT) begin
            for (int i = 0; i < 4; i++) r.coord[i] = c[i][15:0];
          end else begin
            for (int i = 0; i < n; i++) begin
              c[i] = c[i] + 32'(shadow_size[i] / 16'd2);
              if (c[i] >= 32'(shadow_size[i])) c[i] = c[i] - 32'(shadow_size[i]);
            end
            join_needed = 1'b1;
          end
        end
      end
      mrif_pkg::OP_JOIN: begin
        for (int i = 0; i < n; i++) c[i] = 32'(req.coord[i]);
        join_needed = 1'b1;
      end
      default: ;
    endcase
    // Recombine with the last active dimension at stride one.
    if (join_needed) begin
      acc = '0;
      stride = 64'd1;
      for (int i = n - 1; i >= 0; i--) begin
        if (c[i] >= 32'(shadow_size[i])) ok = 1'b0;
        acc = acc + 64'(c[i]) * stride;
        stride = stride * 64'(shadow_size[i]);
      end
      if (acc > 64'hFFFF_FFFF) ok = 1'b0;
      if (ok) r.index = acc[31:0];
    end
    if (!ok) begin
      r = '0;
      r.range_err = 1'b1;
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // Driver: presents queued transactions and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(convert_index(req_on_bus));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req_on_bus = pending_requests.pop_front();
          in_operation <= req_on_bus.op;
          in_linear_index <= req_on_bus.lin;
          in_coord_0 <= req_on_bus.coord[0];
          in_coord_1 <= req_on_bus.coord[1];
          in_coord_2 <= req_on_bus.coord[2];
          in_coord_3 <= req_on_bus.coord[3];
          in_valid <= 1'b1;
          send_gap = no_idle ? 0 : gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_result.index = out_result_index;
        seen_result.coord = {out_coord_3, out_coord_2, out_coord_1, out_coord_0};
        seen_result.range_err = out_range_error;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: index=%h coord=%h err=%b", $time,
                     seen_result.index, seen_result.coord, seen_result.range_err);
        end else begin
          want_result = expected_results.pop_front();
          results_checked++;
          if (seen_result !== want_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp index=%h coord=%h err=%b / got index=%h coord=%h err=%b",
                       $time, want_result.index, want_result.coord, want_result.range_err,
                       seen_result.index, seen_result.coord, seen_result.range_err);
          end
        end
      end
      // Random back-pressure.
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!no_idle && $urandom_range(0, 7) == 0) stall_left = gap_len();
      end
    end
  end

  // Writes all five registers back to back; only called while the block is idle.
  task automatic write_regs(input logic [2:0] dims, input logic [15:0] s0, input logic [15:0] s1,
                            input logic [15:0] s2, input logic [15:0] s3);
    logic [2:0]  idx  [5];
    logic [15:0] vals [5];
    idx  = '{mrif_pkg::CFG_DIM_COUNT, mrif_pkg::CFG_SIZE_0, mrif_pkg::CFG_SIZE_1,
             mrif_pkg::CFG_SIZE_2, mrif_pkg::CFG_SIZE_3};
    vals = '{{13'd0, dims}, s0, s1, s2, s3};
    @(posedge clk);
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      if (idx[k] == mrif_pkg::CFG_DIM_COUNT) shadow_dims = vals[k][2:0];
      else shadow_size[idx[k] - mrif_pkg::CFG_SIZE_0] = vals[k];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(input mrif_pkg::op_t op, input logic [31:0] lin,
                            input logic [15:0] c0, input logic [15:0] c1,
                            input logic [15:0] c2, input logic [15:0] c3);
    index_request_t req;
    req.op = op;
    req.lin = lin;
    req.coord = {c3, c2, c1, c0};
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // Stimulus holds off until every queued transaction has produced its result.
  task automatic drain();
    while (results_checked != requests_queued) @(posedge clk);
  endtask

  // Mostly in-range indexes and coordinates, with boundary values and noise mixed in.
  task automatic queue_random_item();
    index_request_t req;
    int unsigned    n;
    int unsigned    pick;
    logic [63:0]    prod;
    logic [16:0]    edge_val;
    n = active_dims();
    prod = extent_product(n);
    req.op = ($urandom_range(0, 99) < 5) ? mrif_pkg::OP_NONE :
             mrif_pkg::op_t'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    if (pick < 7 && prod != 0)
      req.lin = (prod > 64'hFFFF_FFFF) ? $urandom : 32'(64'($urandom) % prod);
    else if (pick < 8 && prod != 0 && prod <= 64'hFFFF_FFFF)
      req.lin = 32'(prod - 1 + $urandom_range(0, 1));
    else
      req.lin = $urandom;
    for (int i = 0; i < 4; i++) begin
      pick = $urandom_range(0, 99);
      if (i < n && shadow_size[i] != 0 && pick < 75) begin
        req.coord[i] = $urandom_range(0, shadow_size[i] - 1);
      end else if (i < n && pick < 85) begin
        edge_val = 17'(shadow_size[i]) - $urandom_range(0, 1);
        if (shadow_size[i] == 0) edge_val = '0;
        req.coord[i] = (edge_val > 17'd65534) ? 16'd65534 : edge_val[15:0];
      end else begin
        req.coord[i] = $urandom_range(0, 65534);
      end
    end
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // One random register setting followed by a burst of transactions.
  task automatic random_phase(input int unsigned count);
    logic [15:0] sz [4];
    logic [2:0]  dims;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    dims = $urandom_range(1, 4);
    if (kind == 8) dims = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7));
    n = (dims == 0) ? 1 : (dims > 4) ? 4 : dims;
    for (int i = 0; i < 4; i++) begin
      case (kind)
        5, 6:    sz[i] = $urandom_range(1, 400);
        7:       sz[i] = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1000, 65535));
        default: sz[i] = $urandom_range(1, 20);
      endcase
      // Inactive dimensions sometimes get junk extents that must be ignored.
      if (i >= n && $urandom_range(0, 1)) sz[i] = $urandom_range(0, 65535);
    end
    if (kind == 9) sz[$urandom_range(0, n - 1)] = '0;
    write_regs(dims, sz[0], sz[1], sz[2], sz[3]);
    no_idle = ($urandom_range(0, 5) == 0);
    for (int k = 0; k < count; k++) queue_random_item();
    drain();
  endtask

  // Stimulus: directed settings and transactions first, then random phases.
  initial begin
    int unsigned random_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Mixed odd and even extents across four dimensions, product 360.
    write_regs(3'd4, 16'd3, 16'd4, 16'd5, 16'd6);
    queue_item(mrif_pkg::OP_SPLIT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SPLIT, 32'd359, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SPLIT, 32'd360, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SPLIT, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_JOIN, 32'hFFFF_FFFF, 16'd2, 16'd3, 16'd4, 16'd5);
    queue_item(mrif_pkg::OP_JOIN, 32'd0, 16'd0, 16'd0, 16'd0, 16'd6);
    queue_item(mrif_pkg::OP_SHIFT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SHIFT, 32'd359, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_NONE, 32'hFFFF_FFFF, 16'd65534, 16'd65534, 16'd65534,
               16'd65534);
    drain();

    // Largest extents: some results do not fit in 32 bits.
    write_regs(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_item(mrif_pkg::OP_JOIN, 32'd0, 16'd65534, 16'd65534, 16'd65534, 16'd65534);
    queue_item(mrif_pkg::OP_SHIFT, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SPLIT, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_JOIN, 32'd0, 16'd0, 16'd0, 16'd65534, 16'd65534);
    drain();

    // Dimension count zero acts as one; an extent of zero rejects everything.
    write_regs(3'd0, 16'd0, 16'd77, 16'd1, 16'd1);
    queue_item(mrif_pkg::OP_SPLIT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_JOIN, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SHIFT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    drain();

    // Dimension count above the maximum is clamped to four.
    write_regs(3'd7, 16'd2, 16'd1, 16'hFFFF, 16'd7);
    queue_item(mrif_pkg::OP_SPLIT, 32'd917489, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SHIFT, 32'd5, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_JOIN, 32'd0, 16'd1, 16'd0, 16'd65534, 16'd6);
    drain();

    // Two dimensions; inactive extents and coordinates are ignored.
    write_regs(3'd2, 16'd256, 16'd256, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_SPLIT, 32'd65535, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(mrif_pkg::OP_JOIN, 32'd0, 16'd255, 16'd255, 16'd65534, 16'd65534);
    queue_item(mrif_pkg::OP_SHIFT, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    drain();

    random_items = 0;
    while (random_items < 900) begin
      random_phase(30);
      random_items += 30;
    end

    repeat (150) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/mrif_pkg.sv
hdl/mrif_div.sv
hdl/mixed_radix_index_fftshift.sv
hdl/mrif_check.sv
sim/tb_mixed_radix_index_fftshift.sv
